// ===== hdl/tesq_pkg.sv =====
`timescale 1ns / 1ps
package tesq_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int CHANGES_DEF  = 16;
  localparam int WAKES_DEF    = 16;
  localparam int MAX_WIDTH_DEF = 64;

  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 232;

  typedef enum logic [1:0] {
    CMD_CHANGE = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_WAKE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] ps;
    logic [31:0] dl;
    logic [31:0] ep;
  } ts_t;

  typedef struct packed {
    logic [9:0]  sig;
    logic [5:0]  off;
    logic [63:0] val;
    logic [6:0]  wid;
  } change_t;

endpackage

// ===== hdl/timed_event_slot_queue.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                                       | tuser   | tlast
// s_axis  | in  | time_ps, time_delta, time_eps, signal_index, bit_offset,  | command | -
//         |     | new_value, value_width, instance_req                     |         |
// m_axis  | out | status, slot_time_ps, slot_delta, slot_eps, out_signal,  | kind    | last
//         |     | out_offset, out_value, out_width, out_instance           |         |
// Insert: scans the slots one by one through the key memory port, stopping at a matching timestamp.
// Pop: emits the slot's changes, then its wakeups, then rescans all slots for the earliest;
//   each change takes a full pass over the slot's change list (one read port).
// One item at a time; s_axis_tready is high only while idle.
// A result waits in the output register; the block stalls while that register is full and m_axis_tready is low.
// rst is synchronous; it clears slot valid bits and control. Memories are not cleared.
module timed_event_slot_queue
  import tesq_pkg::*;
#(
  parameter int SLOTS            = SLOTS_DEF,
  parameter int CHANGES_PER_SLOT = CHANGES_DEF,
  parameter int WAKES_PER_SLOT   = WAKES_DEF,
  parameter int MAX_WIDTH        = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // time_ps[63:0] time_delta[95:64] time_eps[127:96] signal_index[137:128]
  // bit_offset[143:138] new_value[207:144] value_width[214:208] instance_req[224:215]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[1:0] slot_time_ps[65:2] slot_delta[97:66] slot_eps[129:98]
  // out_signal[139:130] out_offset[145:140] out_value[209:146] out_width[216:210]
  // out_instance[226:217]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW   = $clog2(SLOTS + 1);
  localparam int CW   = $clog2(CHANGES_PER_SLOT + 1);
  localparam int WW   = $clog2(WAKES_PER_SLOT + 1);
  localparam int CIW  = (CHANGES_PER_SLOT > 1) ? $clog2(CHANGES_PER_SLOT) : 1;
  localparam int WIW  = (WAKES_PER_SLOT > 1) ? $clog2(WAKES_PER_SLOT) : 1;
  localparam int CDEP = SLOTS * CHANGES_PER_SLOT;
  localparam int WDEP = SLOTS * WAKES_PER_SLOT;
  localparam int CAW  = $clog2(CDEP);
  localparam int WAW  = $clog2(WDEP);
  localparam int TSW  = $bits(ts_t);
  localparam int KW   = TSW + CW + WW;
  localparam logic [CAW-1:0] CPS_A = CAW'(CHANGES_PER_SLOT);
  localparam logic [WAW-1:0] WPS_A = WAW'(WAKES_PER_SLOT);
  localparam logic [6:0]     MAXW  = 7'(MAX_WIDTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_IRD   = 14'b00000000000010,
    S_ICMP  = 14'b00000000000100,
    S_IUPD  = 14'b00000000001000,
    S_PERR  = 14'b00000000010000,
    S_PRD   = 14'b00000000100000,
    S_PKEY  = 14'b00000001000000,
    S_SRD   = 14'b00000010000000,
    S_SCMP  = 14'b00000100000000,
    S_SEMIT = 14'b00001000000000,
    S_WRD   = 14'b00010000000000,
    S_WEMIT = 14'b00100000000000,
    S_MRD   = 14'b01000000000000,
    S_MCMP  = 14'b10000000000000
  } state_t;

  state_t state;

  // memories
  logic [KW-1:0]           kmem [SLOTS];
  logic [$bits(change_t)-1:0] cmem [CDEP];
  logic [9:0]              wmem [WDEP];
  logic [KW-1:0]           krd;
  change_t                 crd;
  logic [9:0]              wrd;
  logic [SW-1:0]           kaddr;
  logic [CAW-1:0]          caddr;
  logic [WAW-1:0]          waddr;
  logic                    kwe, cwe, wwe;
  logic [SW-1:0]           kwaddr;
  logic [KW-1:0]           kwdata;
  logic [CAW-1:0]          cwaddr;
  change_t                 cwdata;
  logic [WAW-1:0]          wwaddr;

  // control
  logic [SLOTS-1:0]        used;
  logic [UW-1:0]           used_slots;
  logic [SW-1:0]           earliest;
  ts_t                     emin;
  logic                    min_found;
  logic [SW-1:0]           scan_i;
  logic                    hit, free_ok;
  logic [SW-1:0]           hit_slot, free_slot;
  logic [CW-1:0]           cur_cc;
  logic [WW-1:0]           cur_wc;
  ts_t                     cur_ts;
  logic [CIW-1:0]          cj;
  logic [WIW-1:0]          wj;
  logic [CW-1:0]           cdone;
  logic [5:0]              k;
  logic                    best_v, prev_v;
  logic [9+CIW:0]          best_key, prev_key;
  change_t                 best;

  // input latch
  cmd_t                    in_cmd;
  ts_t                     in_ts;
  change_t                 in_chg;
  logic [9:0]              in_inst;

  // output register
  logic                    o_valid;
  kind_t                   o_kind;
  status_t                 o_status;
  ts_t                     o_ts;
  change_t                 o_chg;
  logic [9:0]              o_inst;
  logic                    o_last;
  logic                    can_load;
  logic                    o_load;

  ts_t                     k_ts;
  logic [CW-1:0]           k_cc;
  logic [WW-1:0]           k_wc;
  logic [6:0]              w_in, w_clamp;
  logic [63:0]             v_mask;
  logic [9+CIW:0]          cand_key;
  logic [5:0]              total;
  logic                    is_chg;

  assign {k_ts, k_cc, k_wc} = krd;
  assign can_load = !o_valid || m_axis_tready;
  assign o_load   = can_load && (state == S_IUPD || state == S_PERR ||
                                 state == S_SEMIT || state == S_WEMIT);
  assign total    = 6'(cur_cc) + 6'(cur_wc);
  assign cand_key = {crd.sig, cj};
  assign is_chg   = (in_cmd == CMD_CHANGE);

  assign w_in    = s_axis_tdata[214:208];
  assign w_clamp = (w_in == 7'd0) ? 7'd1 : ((w_in > MAXW) ? MAXW : w_in);
  assign v_mask  = (w_clamp >= 7'd64) ? '1 : ((64'd1 << w_clamp[5:0]) - 64'd1);

  always_ff @(posedge clk) begin
    krd <= kmem[kaddr];
    crd <= cmem[caddr];
    wrd <= wmem[waddr];
    if (kwe) kmem[kwaddr] <= kwdata;
    if (cwe) cmem[cwaddr] <= cwdata;
    if (wwe) wmem[wwaddr] <= in_inst;
  end

  always_comb begin
    kaddr = scan_i;
    if (state == S_PRD) kaddr = earliest;
    caddr = CAW'(earliest) * CPS_A + CAW'(cj);
    waddr = WAW'(earliest) * WPS_A + WAW'(wj);
  end

  // write ports for insert
  always_comb begin
    logic [SW-1:0] ts_slot;
    logic [CW-1:0] cc_base;
    logic [WW-1:0] wc_base;
    ts_slot = hit ? hit_slot : free_slot;
    cc_base = hit ? cur_cc : '0;
    wc_base = hit ? cur_wc : '0;
    kwaddr  = ts_slot;
    kwdata  = {in_ts, cc_base + CW'(is_chg), wc_base + WW'(!is_chg)};
    cwaddr  = CAW'(ts_slot) * CPS_A + CAW'(cc_base);
    cwdata  = in_chg;
    wwaddr  = WAW'(ts_slot) * WPS_A + WAW'(wc_base);
    kwe = 1'b0;
    cwe = 1'b0;
    wwe = 1'b0;
    if (state == S_IUPD && can_load) begin
      if (hit) begin
        if (is_chg && cur_cc < CW'(CHANGES_PER_SLOT)) begin
          kwe = 1'b1;
          cwe = 1'b1;
        end else if (!is_chg && cur_wc < WW'(WAKES_PER_SLOT)) begin
          kwe = 1'b1;
          wwe = 1'b1;
        end
      end else if (free_ok) begin
        kwe = 1'b1;
        cwe = is_chg;
        wwe = !is_chg;
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      used_slots <= '0;
      earliest   <= '0;
      o_valid    <= 1'b0;
      min_found  <= 1'b0;
      hit        <= 1'b0;
      free_ok    <= 1'b0;
      best_v     <= 1'b0;
      prev_v     <= 1'b0;
    end else begin
      if (o_valid && m_axis_tready && !o_load) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_cmd         <= cmd_t'(s_axis_tuser);
            in_ts.ps       <= s_axis_tdata[63:0];
            in_ts.dl       <= s_axis_tdata[95:64];
            in_ts.ep       <= s_axis_tdata[127:96];
            in_chg.sig     <= s_axis_tdata[137:128];
            in_chg.off     <= s_axis_tdata[143:138];
            in_chg.val     <= s_axis_tdata[207:144] & v_mask;
            in_chg.wid     <= w_clamp;
            in_inst        <= s_axis_tdata[224:215];
            scan_i         <= '0;
            hit            <= 1'b0;
            free_ok        <= 1'b0;
            priority case (cmd_t'(s_axis_tuser))
              CMD_CHANGE, CMD_WAKE: state <= S_IRD;
              CMD_POP:  state <= (used_slots == '0) ? S_PERR : S_PRD;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_IRD: state <= S_ICMP;
        S_ICMP: begin
          if (!used[scan_i] && !free_ok) begin
            free_ok   <= 1'b1;
            free_slot <= scan_i;
          end
          if (used[scan_i] && k_ts == in_ts) begin
            hit      <= 1'b1;
            hit_slot <= scan_i;
            cur_cc   <= k_cc;
            cur_wc   <= k_wc;
            state    <= S_IUPD;
          end else if (scan_i == SW'(SLOTS - 1)) begin
            state <= S_IUPD;
          end else begin
            scan_i <= scan_i + 1'b1;
            state  <= S_IRD;
          end
        end
        S_IUPD: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_ts     <= '0;
            o_chg    <= '0;
            o_inst   <= '0;
            o_last   <= 1'b1;
            if (hit && !kwe) begin
              o_kind   <= KIND_ERROR;
              o_status <= ST_FULL;
            end else if (!hit && !free_ok) begin
              o_kind   <= KIND_ERROR;
              o_status <= ST_NO_SLOT;
            end else begin
              o_kind   <= KIND_ACK;
              o_status <= ST_OK;
              if (!hit) begin
                used[free_slot] <= 1'b1;
                used_slots      <= used_slots + 1'b1;
                if (used_slots == '0 || in_ts < emin) begin
                  earliest <= free_slot;
                  emin     <= in_ts;
                end
              end
            end
            state <= S_IDLE;
          end
        end
        S_PERR: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_kind   <= KIND_ERROR;
            o_status <= ST_EMPTY;
            o_ts     <= '0;
            o_chg    <= '0;
            o_inst   <= '0;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_PRD: state <= S_PKEY;
        S_PKEY: begin
          cur_ts <= k_ts;
          cur_cc <= k_cc;
          cur_wc <= k_wc;
          k      <= '0;
          cdone  <= '0;
          cj     <= '0;
          wj     <= '0;
          prev_v <= 1'b0;
          best_v <= 1'b0;
          state  <= (k_cc != '0) ? S_SRD : S_WRD;
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          // pick the smallest (signal, position) above the last one emitted
          if ((!prev_v || cand_key > prev_key) && (!best_v || cand_key < best_key)) begin
            best_v   <= 1'b1;
            best_key <= cand_key;
            best     <= crd;
          end
          if (CW'(cj) == cur_cc - 1'b1) begin
            state <= S_SEMIT;
          end else begin
            cj    <= cj + 1'b1;
            state <= S_SRD;
          end
        end
        S_SEMIT: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_kind   <= KIND_CHANGE;
            o_status <= ST_OK;
            o_ts     <= cur_ts;
            o_chg    <= best;
            o_inst   <= '0;
            o_last   <= (k + 1'b1 == total);
            k        <= k + 1'b1;
            prev_v   <= 1'b1;
            prev_key <= best_key;
            best_v   <= 1'b0;
            cdone    <= cdone + 1'b1;
            cj       <= '0;
            if (cdone + 1'b1 == cur_cc) state <= (cur_wc != '0) ? S_WRD : S_MRD;
            else state <= S_SRD;
            if (cdone + 1'b1 == cur_cc && cur_wc == '0) begin
              used[earliest] <= 1'b0;
              used_slots     <= used_slots - 1'b1;
              scan_i         <= '0;
              min_found      <= 1'b0;
            end
          end
        end
        S_WRD: state <= S_WEMIT;
        S_WEMIT: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_kind   <= KIND_WAKE;
            o_status <= ST_OK;
            o_ts     <= cur_ts;
            o_chg    <= '0;
            o_inst   <= wrd;
            o_last   <= (k + 1'b1 == total);
            k        <= k + 1'b1;
            wj       <= wj + 1'b1;
            if (WW'(wj) + 1'b1 == cur_wc) begin
              // free the slot and rescan
              used[earliest] <= 1'b0;
              used_slots     <= used_slots - 1'b1;
              scan_i         <= '0;
              min_found      <= 1'b0;
              state          <= S_MRD;
            end else begin
              state <= S_WRD;
            end
          end
        end
        S_MRD: begin
          if (!min_found) earliest <= '0;
          state <= S_MCMP;
        end
        S_MCMP: begin
          if (used[scan_i] && (!min_found || k_ts < emin)) begin
            min_found <= 1'b1;
            earliest  <= scan_i;
            emin      <= k_ts;
          end
          if (scan_i == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end else begin
            scan_i <= scan_i + 1'b1;
            state  <= S_MRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_kind;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {5'd0, o_inst, o_chg.wid, o_chg.val, o_chg.off, o_chg.sig,
                          o_ts.ep, o_ts.dl, o_ts.ps, o_status};

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    used_slots == UW'($countones(used)))
    else $error("used slot count out of step with valid bits");

  a_earliest_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && used_slots != '0) |-> used[earliest])
    else $error("earliest pointer names a free slot");

  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEMIT) |-> best_v)
    else $error("change emit without a selected entry");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PKEY) |=> (cur_cc != '0 || cur_wc != '0))
    else $error("popped slot holds no entries");

endmodule
